// ----- hdl/assert_macros.svh -----
// assertion macros used by the reply parser core (qrnp_core)
// no dependencies; SYNTH turns every check into nothing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// check on every rising edge, off while reset is high
`define QRNP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check on every rising edge, reset included
`define QRNP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QRNP_ASSERT(lbl, clk, rst, prop, msg)
`define QRNP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- hdl/qrnp_pkg.sv -----
// types and constants for the reply netstring parser
// no dependencies; used by every module of the block
`default_nettype none

package qrnp_pkg;

  // largest length that may still take another digit
  localparam logic [30:0] LEN_LIMIT = 31'd200000000;

  // characters of the reply stream
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_Z     = 8'h5A;

  // reply status codes
  localparam logic [1:0] ST_K = 2'd0;
  localparam logic [1:0] ST_D = 2'd1;
  localparam logic [1:0] ST_Z = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_DIGIT     = 3'd1;
  localparam logic [2:0] ERR_TOO_LARGE = 3'd2;
  localparam logic [2:0] ERR_ZERO_LEN  = 3'd3;
  localparam logic [2:0] ERR_LETTER    = 3'd4;
  localparam logic [2:0] ERR_NO_COMMA  = 3'd5;

  // parser phase
  typedef enum logic [2:0] {
    PH_LEN,
    PH_LETTER,
    PH_TEXT,
    PH_COMMA,
    PH_DONE,
    PH_HALT
  } phase_t;

  // one result handed from the parser to the output register
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic [2:0] err;
    logic       fin;
    logic       any;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/qrnp_core.sv -----
// input register, config register and the parsing state machine
// depends on qrnp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module qrnp_core
  import qrnp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        cfg_valid,
  input  wire logic [15:0] cfg_data,
  input  wire logic        out_free,
  output result_t          res
);

  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        advance;

  logic [15:0] recipient_count;

  phase_t      phase, phase_next;
  logic [30:0] remaining_length, remaining_length_next;
  logic [1:0]  status_letter, status_letter_next;
  logic [15:0] replies_done, replies_done_next;
  logic        accepted_seen, accepted_seen_next;

  logic        is_digit;
  logic [30:0] len_times_ten;
  logic [30:0] len_dec;
  logic [16:0] done_count;
  logic        done_fin;

  // byte moves on when the result register can take whatever it causes
  assign advance  = hold_valid && out_free;
  assign in_ready = !hold_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= rx_byte;
    end
  end

  // expected reply count
  always_ff @(posedge clk) begin
    if (rst) begin
      recipient_count <= 16'd1;
    end else if (cfg_valid) begin
      recipient_count <= cfg_data;
    end
  end

  // datapath pieces
  assign is_digit      = (hold_byte >= CH_ZERO) && (hold_byte <= CH_NINE);
  assign len_times_ten = {remaining_length[27:0], 3'b000}
                       + {remaining_length[29:0], 1'b0}
                       + {27'd0, hold_byte[3:0]};
  assign len_dec       = remaining_length - 31'd1;
  assign done_count    = {1'b0, replies_done} + 17'd1;
  assign done_fin      = done_count >= {1'b0, recipient_count};

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_LEN;
      remaining_length <= '0;
      status_letter    <= ST_K;
      replies_done     <= '0;
      accepted_seen    <= 1'b0;
    end else begin
      phase            <= phase_next;
      remaining_length <= remaining_length_next;
      status_letter    <= status_letter_next;
      replies_done     <= replies_done_next;
      accepted_seen    <= accepted_seen_next;
    end
  end

  // next state and result
  always_comb begin
    phase_next            = phase;
    remaining_length_next = remaining_length;
    status_letter_next    = status_letter;
    replies_done_next     = replies_done;
    accepted_seen_next    = accepted_seen;
    res                   = '0;
    res.any               = accepted_seen;

    if (advance) begin
      case (phase)
        PH_LEN: begin
          if (hold_byte == CH_COLON) begin
            if (remaining_length == '0) begin
              phase_next = PH_HALT;
              res.valid  = 1'b1;
              res.err    = ERR_ZERO_LEN;
            end else begin
              phase_next = PH_LETTER;
            end
          end else if (remaining_length > LEN_LIMIT) begin
            phase_next = PH_HALT;
            res.valid  = 1'b1;
            res.err    = ERR_TOO_LARGE;
          end else if (!is_digit) begin
            phase_next = PH_HALT;
            res.valid  = 1'b1;
            res.err    = ERR_DIGIT;
          end else begin
            remaining_length_next = len_times_ten;
          end
        end
        PH_LETTER: begin
          remaining_length_next = len_dec;
          phase_next = (len_dec != '0) ? PH_TEXT : PH_COMMA;
          if (hold_byte == CH_K) begin
            status_letter_next = ST_K;
          end else if (hold_byte == CH_D) begin
            status_letter_next = ST_D;
          end else if (hold_byte == CH_Z) begin
            status_letter_next = ST_Z;
          end else begin
            phase_next = PH_HALT;
            res.valid  = 1'b1;
            res.err    = ERR_LETTER;
          end
        end
        PH_TEXT: begin
          remaining_length_next = len_dec;
          if (len_dec == '0) begin
            phase_next = PH_COMMA;
          end
        end
        PH_COMMA: begin
          if (hold_byte != CH_COMMA) begin
            phase_next = PH_HALT;
            res.valid  = 1'b1;
            res.err    = ERR_NO_COMMA;
          end else begin
            accepted_seen_next    = accepted_seen || (status_letter == ST_K);
            replies_done_next     = done_count[15:0];
            remaining_length_next = '0;
            phase_next            = done_fin ? PH_DONE : PH_LEN;
            res.valid             = 1'b1;
            res.status            = status_letter;
            res.fin               = done_fin;
            res.any               = accepted_seen || (status_letter == ST_K);
          end
        end
        default: begin
          // finished or halted: bytes are dropped
        end
      endcase
    end
  end

  // checks
  `QRNP_ASSERT(a_halt_sticks, clk, rst, phase == PH_HALT |=> phase == PH_HALT, "left halt without reset")
  `QRNP_ASSERT(a_done_sticks, clk, rst, phase == PH_DONE |=> phase == PH_DONE, "left done without reset")
  `QRNP_ASSERT(a_len_bound, clk, rst, remaining_length <= 31'd2000000009, "length beyond bound")
  `QRNP_ASSERT(a_err_clean, clk, rst, (res.valid && res.err != ERR_NONE) |-> (res.status == ST_K && !res.fin), "error result carries status")
  `QRNP_ASSERT(a_fin_done, clk, rst, (res.valid && res.fin) |=> phase == PH_DONE, "final reply did not end parsing")

endmodule

`default_nettype wire

// ----- hdl/qrnp_out.sv -----
// result register between the parser and the output channel
// depends on qrnp_pkg
`default_nettype none

module qrnp_out
  import qrnp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire result_t    res,
  output logic            out_free,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      reply_status,
  output logic [2:0]      error_code,
  output logic            final_reply,
  output logic            any_accepted
);

  // room for a new result this cycle
  assign out_free = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (res.valid) begin
      reply_status <= res.status;
      error_code   <= res.err;
      final_reply  <= res.fin;
      any_accepted <= res.any;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/qmtp_reply_netstring_parser.sv -----
// top level of the reply netstring parser
// depends on qrnp_pkg, qrnp_core and qrnp_out
//
//   channel  signals                   payload
//   in       in_valid / in_ready       rx_byte
//   out      out_valid / out_ready     reply_status, error_code, final_reply, any_accepted
//   cfg      cfg_valid / cfg_ready     cfg_data (recipient_count)
//
// one byte per cycle while the output is not stalled: a byte waits in the input register,
// the parser state machine updates as it leaves, and a result lands in the output register.
// a byte passes the input register and its result the output register before it is valid at the output.
// reset clears the parser to the length phase with recipient_count at 1.
// a stalled output holds the input register; cfg_ready is always high.
`default_nettype none

module qmtp_reply_netstring_parser
  import qrnp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       reply_status,
  output logic [2:0]       error_code,
  output logic             final_reply,
  output logic             any_accepted,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  result_t res;
  logic    out_free;

  assign cfg_ready = 1'b1;

  // parser
  qrnp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_free  (out_free),
    .res       (res)
  );

  // result register
  qrnp_out u_out (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .out_free     (out_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .reply_status (reply_status),
    .error_code   (error_code),
    .final_reply  (final_reply),
    .any_accepted (any_accepted)
  );

endmodule

`default_nettype wire

// ----- sim/tb_qmtp_reply_netstring_parser.sv -----
// testbench for qmtp_reply_netstring_parser: QMTP reply byte streams against a netstring parser model
// depends on qrnp_pkg and the RTL of the block; feeds bytes from a queue, checks every result field in order

module tb_qmtp_reply_netstring_parser;
  import qrnp_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 8;
  localparam int RANDOM_BYTES  = 1225;

  // kinds of entries in the byte feed
  typedef enum logic [1:0] {
    FEED_BYTE,
    FEED_COUNT,
    FEED_DRAIN
  } feed_kind_t;

  typedef struct {
    feed_kind_t  kind;
    logic [15:0] value;
  } feed_entry_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] err;
    logic       fin;
    logic       any;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  reply_status;
  logic [2:0]  error_code;
  logic        final_reply;
  logic        any_accepted;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'h0000;

  feed_entry_t rx_feed[$];
  reply_t      replies_due[$];
  int          mismatches = 0;
  int          settle = 0;
  int unsigned cyc = 0;
  wire         calm = (cyc >= 400 && cyc < 1100);

  // stimulus bookkeeping
  int unsigned bytes_planned = 0;
  int unsigned replies_planned = 0;
  logic [7:0]  letters[3] = '{CH_K, CH_D, CH_Z};

  // parser model state
  phase_t      rx_phase = PH_LEN;
  logic [30:0] len_left = '0;
  logic [1:0]  letter_st = ST_K;
  logic [15:0] replies_seen = '0;
  logic        accepted_any = 1'b0;
  logic [15:0] rcpt_limit = 16'd1;

  qmtp_reply_netstring_parser DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .reply_status (reply_status),
    .error_code   (error_code),
    .final_reply  (final_reply),
    .any_accepted (any_accepted),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) cyc <= cyc + 1;

  // protocol error: the parser stops for good and reports the code
  function automatic void halt_with(input logic [2:0] code);
    rx_phase = PH_HALT;
    replies_due.push_back('{ST_K, code, 1'b0, accepted_any});
  endfunction

  // advance the parser model by one received byte
  function automatic void parse_rx_byte(input logic [7:0] b);
    logic [16:0] next_done;
    logic        fin;
    case (rx_phase)
      PH_LEN: begin
        if (b == CH_COLON) begin
          if (len_left == 0) halt_with(ERR_ZERO_LEN);
          else rx_phase = PH_LETTER;
        end else if (len_left > LEN_LIMIT) begin
          halt_with(ERR_TOO_LARGE);
        end else if (b < CH_ZERO || b > CH_NINE) begin
          halt_with(ERR_DIGIT);
        end else begin
          len_left = len_left * 31'd10 + 31'(b - CH_ZERO);
        end
      end
      PH_LETTER: begin
        len_left = len_left - 31'd1;
        if (b == CH_K) letter_st = ST_K;
        else if (b == CH_D) letter_st = ST_D;
        else if (b == CH_Z) letter_st = ST_Z;
        if (b != CH_K && b != CH_D && b != CH_Z) halt_with(ERR_LETTER);
        else rx_phase = (len_left != 0) ? PH_TEXT : PH_COMMA;
      end
      PH_TEXT: begin
        len_left = len_left - 31'd1;
        if (len_left == 0) rx_phase = PH_COMMA;
      end
      PH_COMMA: begin
        if (b != CH_COMMA) begin
          halt_with(ERR_NO_COMMA);
        end else begin
          if (letter_st == ST_K) accepted_any = 1'b1;
          next_done = {1'b0, replies_seen} + 17'd1;
          fin = next_done >= {1'b0, rcpt_limit};
          replies_seen = next_done[15:0];
          len_left = '0;
          rx_phase = fin ? PH_DONE : PH_LEN;
          replies_due.push_back('{letter_st, ERR_NONE, fin, accepted_any});
        end
      end
      default: ;
    endcase
  endfunction

  task automatic plan_byte(input logic [7:0] b);
    rx_feed.push_back('{FEED_BYTE, {8'h00, b}});
    bytes_planned++;
  endtask

  task automatic plan_pause();
    rx_feed.push_back('{FEED_DRAIN, 16'h0000});
  endtask

  // register writes go in only once the parser has gone quiet
  task automatic plan_count(input logic [15:0] n);
    plan_pause();
    rx_feed.push_back('{FEED_COUNT, n});
  endtask

  task automatic plan_length(input int unsigned n, input int unsigned zeros);
    string digits;
    digits = $sformatf("%0d", n);
    repeat (zeros) plan_byte(CH_ZERO);
    for (int i = 0; i < digits.len(); i++) plan_byte(digits[i]);
  endtask

  task automatic plan_head(input int unsigned n, input int unsigned zeros,
                           input logic [7:0] letter);
    plan_length(n, zeros);
    plan_byte(CH_COLON);
    plan_byte(letter);
  endtask

  // well-formed reply with random text
  task automatic plan_reply(input int unsigned n, input int unsigned zeros);
    plan_head(n, zeros, letters[$urandom_range(2)]);
    repeat (n - 1) plan_byte(8'($urandom_range(255)));
    plan_byte(CH_COMMA);
    replies_planned++;
  endtask

  // byte and count driver and model update on each transfer
  always @(posedge clk) begin
    logic in_nxt;
    logic cfg_nxt;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      in_nxt = in_valid && !in_ready;
      cfg_nxt = cfg_valid && !cfg_ready;
      if (in_valid && in_ready) parse_rx_byte(rx_byte);
      if (cfg_valid && cfg_ready) rcpt_limit = cfg_data;
      if (!in_nxt && !cfg_nxt) begin
        if (settle > 0) begin
          settle--;
        end else if (rx_feed.size() != 0) begin
          case (rx_feed[0].kind)
            FEED_BYTE: begin
              if (calm || $urandom_range(99) >= 31) begin
                in_nxt = 1'b1;
                rx_byte <= rx_feed[0].value[7:0];
                void'(rx_feed.pop_front());
              end
            end
            FEED_COUNT: begin
              cfg_nxt = 1'b1;
              cfg_data <= rx_feed[0].value;
              void'(rx_feed.pop_front());
            end
            default: begin
              if (replies_due.size() == 0) begin
                settle = SETTLE_CYCLES;
                void'(rx_feed.pop_front());
              end
            end
          endcase
        end
      end
      in_valid <= in_nxt;
      cfg_valid <= cfg_nxt;
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $error("unexpected result: status %0d code %0d", reply_status, error_code);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          if (reply_status !== want.status) begin
            $error("reply_status: expected %0d, got %0d", want.status, reply_status);
            mismatches++;
          end
          if (error_code !== want.err) begin
            $error("error_code: expected %0d, got %0d", want.err, error_code);
            mismatches++;
          end
          if (final_reply !== want.fin) begin
            $error("final_reply: expected %0d, got %0d", want.fin, final_reply);
            mismatches++;
          end
          if (any_accepted !== want.any) begin
            $error("any_accepted: expected %0d, got %0d", want.any, any_accepted);
            mismatches++;
          end
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 31);
    end
  end

  // stimulus plan, then wait for the stream to drain
  initial begin
    int          lim;
    int unsigned r;
    int unsigned n;
    logic [7:0]  bad;

    // open with the largest count so the session does not close early
    plan_count(16'hFFFF);

    // shortest reply: letter followed directly by the comma
    plan_head(1, 0, CH_K);
    plan_byte(CH_COMMA);
    // leading zeros in the length, all-ones text byte
    plan_head(2, 2, CH_D);
    plan_byte(8'hFF);
    plan_byte(CH_COMMA);
    // separator characters inside the text are just text
    plan_head(4, 0, CH_Z);
    plan_byte(8'h00);
    plan_byte(CH_COLON);
    plan_byte(CH_COMMA);
    plan_byte(CH_COMMA);
    plan_head(3, 0, CH_K);
    plan_byte(8'h55);
    plan_byte(8'hAA);
    plan_byte(CH_COMMA);
    replies_planned += 4;
    // sender waits here until every result so far has come back
    plan_pause();

    // random replies, mostly short, with pauses and count changes
    while (bytes_planned < RANDOM_BYTES) begin
      r = $urandom_range(99);
      if (r < 3) begin
        plan_pause();
      end else if (r < 6) begin
        if ($urandom_range(1)) plan_count(16'hFFFF);
        else plan_count(16'($urandom_range(65535, replies_planned + 400)));
      end
      r = $urandom_range(99);
      if (r < 80) n = $urandom_range(8, 1);
      else if (r < 95) n = $urandom_range(40, 9);
      else n = $urandom_range(300, 41);
      plan_reply(n, ($urandom_range(9) < 2) ? $urandom_range(3, 1) : 0);
    end

    // closing: either the last reply or one protocol error, which halts the parser
    case ($urandom_range(5))
      0: begin
        case ($urandom_range(4))
          0: lim = 0;
          1: lim = 1;
          2: lim = $urandom_range(replies_planned);
          3: lim = replies_planned + 1;
          default: lim = replies_planned + 2;
        endcase
        plan_count(lim[15:0]);
        do plan_reply($urandom_range(6, 1), 0); while (replies_planned < lim);
        // bytes after the final reply are dropped
        repeat ($urandom_range(8, 1)) plan_byte(8'($urandom_range(255)));
      end
      1: begin
        repeat ($urandom_range(3)) plan_byte(8'(CH_ZERO + $urandom_range(9)));
        if ($urandom_range(1)) bad = 8'($urandom_range(8'h2F));
        else bad = 8'($urandom_range(8'hFF, 8'h3B));
        plan_byte(bad);
      end
      2: begin
        if ($urandom_range(1)) plan_length(2000000009, 0);
        else plan_length($urandom_range(999999999, 300000000), $urandom_range(1));
        do bad = 8'($urandom_range(255)); while (bad == CH_COLON);
        plan_byte(bad);
      end
      3: begin
        repeat ($urandom_range(2)) plan_byte(CH_ZERO);
        plan_byte(CH_COLON);
      end
      4: begin
        plan_length($urandom_range(9, 1), 0);
        plan_byte(CH_COLON);
        do bad = 8'($urandom_range(255)); while (bad == CH_K || bad == CH_D || bad == CH_Z);
        plan_byte(bad);
      end
      default: begin
        n = $urandom_range(6, 1);
        plan_head(n, 0, letters[$urandom_range(2)]);
        repeat (n - 1) plan_byte(8'($urandom_range(255)));
        do bad = 8'($urandom_range(255)); while (bad == CH_COMMA);
        plan_byte(bad);
      end
    endcase

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (rx_feed.size() != 0 || in_valid || cfg_valid || replies_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
